### rtl/core/assert_macros.svh
// Assertion macros shared by the cipher RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KBLC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("kblc assertion failed");
`define KBLC_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("kblc forbidden condition seen");
`else
`define KBLC_ASSERT(lbl, clk_s, rstn_s, prop)
`define KBLC_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

### rtl/core/kblc_pkg.sv
// Types, constants and cipher functions shared by the keyed cipher modules.
`timescale 1ns / 1ps
package kblc_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int KEY_IDX_W = $clog2(NUM_KEYS);
  localparam logic [7:0] START_STATE = 8'hFC;

  // Entry i sits at index i: entry 0 is 0xff.
  localparam logic [7:0][7:0] FIRST_MAP = {
    8'h7f, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe, 8'hff
  };

  typedef logic [7:0]      byte_t;
  typedef logic [7:0][7:0] map_t;       // [entry] of 8-bit rows
  typedef logic [7:0][7:0][7:0] coef_tab_t;  // [step][entry]

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    byte_t      data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    byte_t state;
    byte_t res;
  } step_res_t;

  function automatic byte_t grow(input byte_t r);
    return {r[6:0], r[7] ^ r[6]};
  endfunction

  function automatic coef_tab_t build_coefs(input map_t keys);
    coef_tab_t c;
    logic [2:0] bp;
    for (int b = 0; b < 8; b++) c[0][b] = keys[b];
    for (int s = 1; s < 8; s++) begin
      for (int b = 0; b < 7; b++) begin
        bp = 3'(b + 7);
        c[s][b] = grow(c[s-1][bp]);
      end
      c[s][7] = grow(c[s-1][6]) ^ c[s][0];
    end
    return c;
  endfunction

  function automatic byte_t lin_map(input byte_t x, input map_t tab);
    byte_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) r = r ^ tab[i];
    end
    return r;
  endfunction

  // One data byte: first map, then eight keyed bit steps.
  function automatic step_res_t cipher_step(input byte_t st, input byte_t data,
                                            input coef_tab_t c);
    step_res_t o;
    byte_t     s;
    s = lin_map(st, FIRST_MAP);
    o.res = '0;
    for (int k = 0; k < 8; k++) begin
      o.res[k] = s[k];
      if (!data[k]) s = lin_map(s, c[k]);
    end
    o.state = s;
    return o;
  endfunction

endpackage

### rtl/core/kblc_front.sv
// Front end: key registers, coefficient table and request intake into the queue.
`timescale 1ns / 1ps
module kblc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kblc_pkg::KEY_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [7:0]                      in_data_in,
  input  logic                            q_full,
  output logic                            q_push,
  output kblc_pkg::item_t                 q_push_item,
  output kblc_pkg::coef_tab_t             coefs
);

  kblc_pkg::map_t key_r;
  kblc_pkg::map_t key_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    if (cfg_valid && cfg_ready) key_nxt[cfg_index] = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // The user must change keys only while idle (the block does not enforce it), so the table can stay combinational.
  assign coefs = kblc_pkg::build_coefs(key_r);

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_push_item.kind = in_op ? kblc_pkg::KIND_DATA : kblc_pkg::KIND_START;
    q_push_item.data = in_data_in;
  end

endmodule

### rtl/core/kblc_queue.sv
// Two-entry request queue between the front end and the cipher back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kblc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kblc_pkg::item_t   push_item,
  input  logic              pop,
  output kblc_pkg::q_head_t head,
  output logic              full
);

  kblc_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `KBLC_ASSERT_NEVER(a_q_overflow, clk, rst_n, count_r == 2'd3)
  `KBLC_ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && count_r == 2'd0)
  `KBLC_ASSERT(a_q_ptr_gap, clk, rst_n, count_r != 2'd1 || wr_ptr_r != rd_ptr_r)

endmodule

### rtl/core/kblc_back.sv
// Back end: cipher state, per-byte transform and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kblc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  kblc_pkg::q_head_t   head,
  output logic                pop,
  input  kblc_pkg::coef_tab_t coefs,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_out
);

  kblc_pkg::byte_t     state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  kblc_pkg::byte_t     out_data_r, out_data_nxt;
  logic                is_data;
  logic                out_free;
  logic                pop_data;
  logic                pop_start;
  kblc_pkg::step_res_t step;

  assign is_data   = (head.item.kind == kblc_pkg::KIND_DATA);
  assign out_free  = !out_valid_r || !out_stall;
  // A start request needs no result slot and always drains.
  assign pop       = head.valid && (!is_data || out_free);
  assign pop_data  = pop && is_data;
  assign pop_start = pop && !is_data;

  assign step = kblc_pkg::cipher_step(state_r, head.item.data, coefs);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop_start) state_nxt = kblc_pkg::START_STATE;
    if (pop_data) begin
      state_nxt     = step.state;
      out_valid_nxt = 1'b1;
      out_data_nxt  = step.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  `KBLC_ASSERT(a_b_data_shows, clk, rst_n, pop_data |=> out_valid_r)
  `KBLC_ASSERT(a_b_start_load, clk, rst_n, pop_start |=> state_r == kblc_pkg::START_STATE)
  `KBLC_ASSERT(a_b_drain, clk, rst_n, out_valid_r && !out_stall && !pop_data |=> !out_valid_r)

endmodule

### rtl/core/keyed_bitwise_lock_cipher.sv
// Keyed bitwise byte cipher top level: front end, request queue and back end.
// A data request accepted into the queue is transformed from the queue head, and its
// result is captured in the result register, which drives out_valid.
// Throughput: one request per cycle unless out_stall holds back the result; the whole
// per-byte transform is one combinational pass in the back end, gated by the result register.
// Reset (rst_n low, synchronous) clears keys, cipher state, queue and result valid.
`timescale 1ns / 1ps
module keyed_bitwise_lock_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kblc_pkg::KEY_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_data_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_data_out
);

  logic                q_full;
  logic                q_push;
  kblc_pkg::item_t     q_push_item;
  logic                q_pop;
  kblc_pkg::q_head_t   q_head;
  kblc_pkg::coef_tab_t coefs;

  kblc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_data_in  (in_data_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_item (q_push_item),
    .coefs       (coefs)
  );

  kblc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full)
  );

  kblc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .pop          (q_pop),
    .coefs        (coefs),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out)
  );

endmodule

### sim/keyed_bitwise_lock_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyed bitwise lock cipher: predictor, stimulus, flow control.
module keyed_bitwise_lock_cipher_tb;
  import kblc_pkg::*;

  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    TAIL_CYCLES   = 8;
  localparam int    HOLD_CYCLES   = 160;
  localparam int    RANDOM_PHASES = 6;
  localparam int    PHASE_ITEMS   = 113;
  localparam byte_t SESSION_SEED  = 8'hFC;
  // Row i sits at index i, so row 0 is 0xff.
  localparam map_t  PRE_MIX = {
    8'h7f, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe, 8'hff
  };

  class cipher_scoreboard;
    map_t  keys;
    byte_t state;
    byte_t expected_bytes[$];
    int    errors;
    int    starts_seen;
    int    bytes_sent;
    int    bytes_checked;

    function new();
      keys          = '0;
      state         = '0;
      errors        = 0;
      starts_seen   = 0;
      bytes_sent    = 0;
      bytes_checked = 0;
    endfunction

    function void set_key(input int idx, input byte_t value);
      keys[idx] = value;
    endfunction

    static function byte_t feed(input byte_t r);
      return {r[6:0], r[7] ^ r[6]};
    endfunction

    // XOR of the rows selected by the set bits of x.
    static function byte_t mix(input byte_t x, input map_t rows);
      byte_t r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
        if (x[i]) r = r ^ rows[i];
      end
      return r;
    endfunction

    function byte_t encipher(input byte_t data);
      map_t  step_rows [8];
      byte_t s;
      byte_t res;
      for (int b = 0; b < 8; b++) step_rows[0][b] = keys[b];
      for (int k = 1; k < 8; k++) begin
        for (int b = 0; b < 7; b++) step_rows[k][b] = feed(step_rows[k-1][(b + 7) % 8]);
        step_rows[k][7] = feed(step_rows[k-1][6]) ^ step_rows[k][0];
      end
      s   = mix(state, PRE_MIX);
      res = '0;
      for (int k = 0; k < 8; k++) begin
        res[k] = s[k];
        if (!data[k]) s = mix(s, step_rows[k]);
      end
      state = s;
      return res;
    endfunction

    function void note_request(input item_kind_t kind, input byte_t data);
      if (kind == KIND_START) begin
        state = SESSION_SEED;
        starts_seen++;
      end else begin
        expected_bytes.push_back(encipher(data));
        bytes_sent++;
      end
    endfunction

    function void check_result(input byte_t got);
      byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("data_out: expected nothing, actual %02h", got);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (want !== got) begin
          $error("data_out: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [KEY_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 in_op      = 1'b0;
  logic [7:0]           in_data_in = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [7:0]           out_data_out;

  cipher_scoreboard board = new();
  bit  calm         = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left    = 0;
  int  cycle_count  = 0;
  int  key_settings = 0;

  keyed_bitwise_lock_cipher u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_key(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_request(item_kind_t'(in_op), in_data_in);
      if (out_valid && !out_stall) board.check_result(out_data_out);
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on demand.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_stall    = 1'b1;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < 11);
    end
  end

  function automatic byte_t pick_data();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 8'h00;
    if (roll < 16) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  // Entered and left at a falling edge; valid stays high on exit until a gap or a wait lowers it.
  task automatic send_request(input item_kind_t kind, input byte_t data);
    int gap;
    if (!calm && $urandom_range(99) < 5) begin
      gap      = $urandom_range(4, 1);
      in_valid = 1'b0;
      repeat (gap) begin
        in_op      = 1'($urandom_range(1));
        in_data_in = 8'($urandom_range(255));
        @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    in_op      = kind;
    in_data_in = data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results(input int tail);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic load_keys(input map_t k);
    for (int i = 0; i < NUM_KEYS; i++) begin
      cfg_valid = 1'b1;
      cfg_index = KEY_IDX_W'(i);
      cfg_data  = k[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    key_settings++;
  endtask

  // Mostly sessions: a start followed by a run of data bytes; the rest is loose requests.
  task automatic run_phase(input int items, input bit pause_midway);
    int  sent;
    int  run_len;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < items) begin
      if ($urandom_range(99) < 85) begin
        send_request(KIND_START, byte_t'($urandom_range(255)));
        sent++;
        run_len = $urandom_range(12, 1);
        repeat (run_len) begin
          send_request(KIND_DATA, pick_data());
          sent++;
        end
      end else begin
        send_request(item_kind_t'($urandom_range(1)), byte_t'($urandom_range(255)));
        sent++;
      end
      if (pause_midway && !paused && sent >= items / 2) begin
        wait_for_results(0);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    map_t k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Keys still at reset; data before any start works from the cleared state.
    send_request(KIND_DATA, 8'h00);
    send_request(KIND_DATA, 8'hFF);
    send_request(KIND_START, 8'hA5);
    send_request(KIND_DATA, 8'h00);
    send_request(KIND_DATA, 8'hFF);

    wait_for_results(TAIL_CYCLES);
    load_keys('1);
    send_request(KIND_START, 8'h00);
    send_request(KIND_DATA, 8'h00);
    send_request(KIND_DATA, 8'hFF);
    send_request(KIND_DATA, 8'h01);
    send_request(KIND_DATA, 8'h80);
    send_request(KIND_DATA, 8'hAA);
    send_request(KIND_DATA, 8'h55);
    send_request(KIND_START, 8'hFF);
    send_request(KIND_START, 8'h3C);
    send_request(KIND_DATA, 8'h0F);

    wait_for_results(TAIL_CYCLES);
    for (int i = 0; i < NUM_KEYS; i++) k[i] = 8'h01 << i;
    load_keys(k);
    send_request(KIND_DATA, 8'h7F);
    send_request(KIND_DATA, 8'hFE);
    send_request(KIND_START, 8'h00);
    send_request(KIND_DATA, 8'hF0);
    send_request(KIND_DATA, 8'h0F);
    send_request(KIND_DATA, 8'h5A);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_results(TAIL_CYCLES);
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (p == 1) k[i] = i[0] ? 8'hFF : 8'h00;
        else k[i] = byte_t'($urandom_range(255));
      end
      load_keys(k);
      calm = (p == 2);
      if (p == 3) hold_request = 1'b1;
      run_phase(PHASE_ITEMS, p == 4);
      calm = 1'b0;
    end

    wait_for_results(TAIL_CYCLES);
    $display("Sent %0d start and %0d data requests under %0d key settings;",
             board.starts_seen, board.bytes_sent, key_settings);
    $display("checked %0d response bytes, %0d mismatches.", board.bytes_checked, board.errors);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/kblc_pkg.sv
rtl/core/kblc_front.sv
rtl/core/kblc_queue.sv
rtl/core/kblc_back.sv
rtl/core/keyed_bitwise_lock_cipher.sv
sim/keyed_bitwise_lock_cipher_tb.sv
